### sv/insertion_sort_with_step_count_assert.svh
// Assertion macros for the insertion sorter and its port checker.
// Each macro places one labeled concurrent assertion, reset disabled.
`ifndef INSERTION_SORT_WITH_STEP_COUNT_ASSERT_SVH
`define INSERTION_SORT_WITH_STEP_COUNT_ASSERT_SVH

// Same-cycle implication.
`define ISWS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication.
`define ISWS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

### sv/isws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isws_pkg
// Shared widths, defaults and the cell control type of the insertion sorter.
// ----------------------------------------------------------------------------
package isws_pkg;

  localparam int VALUE_W           = 32;
  localparam int STEP_W            = 13;
  localparam int MAX_ITEMS_DEFAULT = 16;

  typedef struct packed {
    logic insert;      // place the broadcast value, shift greater ones up
    logic shift_down;  // move every entry one cell toward the output
  } cell_ctrl_t;

endpackage

### sv/insertion_sort_with_step_count.sv
`timescale 1ns / 1ps
// An unmarked value is stored; busy stays low.
// Throughput: one value per cycle while busy is low.
// A marked value is stored, then the batch streams out from the next cycle,
// one result per cycle until every stored item has left, while busy is high.
// Reset clears the count, step total, drop flag and every cell's valid bit.
// ----------------------------------------------------------------------------
// insertion_sort_with_step_count
// Chain of compare cells that keeps a batch in ascending order, counts the
// insertion sort steps and streams the batch out after the marked beat.
// ----------------------------------------------------------------------------
module insertion_sort_with_step_count #(
  parameter int MAX_ITEMS = isws_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [isws_pkg::VALUE_W-1:0] value,
  input  logic                                last,
  output logic                                result_strobe,
  output logic signed [isws_pkg::VALUE_W-1:0] sorted_value,
  output logic                                last_out,
  output logic [isws_pkg::STEP_W-1:0]         step_count,
  output logic                                overflow
);
  import isws_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;
  localparam logic [STEP_W:0] STEP_SAT = {1'b0, {STEP_W{1'b1}}};

  logic              state;
  logic [CW-1:0]     item_count;
  logic [CW-1:0]     item_count_next;
  logic [CW-1:0]     remaining;
  logic [STEP_W-1:0] step_total;
  logic              dropped_flag;

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              full;
  logic [CW-1:0]     ins_pos;
  logic [CW-1:0]     greater;
  logic [STEP_W:0]   step_sum;

  logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]      cell_valid;
  logic [MAX_ITEMS-1:0]      cell_ge;
  logic [MAX_ITEMS-1:0]      cell_edge;

  assign busy   = (state == ST_EMIT);
  assign accept = start && !busy;
  assign full   = (item_count == CW'(MAX_ITEMS));

  assign ctrl.insert     = accept && !full;
  assign ctrl.shift_down = busy;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv;
    logic signed [VALUE_W-1:0] rv;
    logic                      lval;
    logic                      lge;
    logic                      rval;

    if (i == 0) begin : g_first
      assign lv   = '0;
      assign lval = 1'b0;
      assign lge  = 1'b0;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lval = cell_valid[i-1];
      assign lge  = cell_ge[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_top
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_below
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end

    // The ge flags form a thermometer; its rising edge marks the slot.
    assign cell_edge[i] = cell_ge[i] && !lge;

    isws_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (value),
      .left_value (lv),
      .left_valid (lval),
      .left_ge    (lge),
      .right_value(rv),
      .right_valid(rval),
      .value_q    (cell_value[i]),
      .valid_q    (cell_valid[i]),
      .ge         (cell_ge[i])
    );
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (cell_edge[i]) begin
        ins_pos = ins_pos | CW'(i);
      end
    end
  end

  // Every stored value above the slot is strictly greater than the new one.
  assign greater  = item_count - ins_pos;
  assign step_sum = {1'b0, step_total} + (STEP_W+1)'(2) + (STEP_W+1)'({greater, 1'b0});

  assign item_count_next = full ? item_count : item_count + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      item_count   <= '0;
      remaining    <= '0;
      step_total   <= '0;
      dropped_flag <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item_count <= item_count_next;
            if (full) begin
              dropped_flag <= 1'b1;
            end else if (item_count != '0) begin
              step_total <= (step_sum > STEP_SAT) ? STEP_SAT[STEP_W-1:0]
                                                  : step_sum[STEP_W-1:0];
            end
            if (last) begin
              state     <= ST_EMIT;
              remaining <= item_count_next;
            end
          end
        end
        ST_EMIT: begin
          remaining <= remaining - CW'(1);
          if (remaining == CW'(1)) begin
            state        <= ST_IDLE;
            item_count   <= '0;
            step_total   <= '0;
            dropped_flag <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_strobe = busy;
  assign sorted_value  = cell_value[0];
  assign last_out      = busy && (remaining == CW'(1));
  assign step_count    = step_total;
  assign overflow      = dropped_flag;

endmodule

### sv/isws_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isws_cell
// One cell of the sorting chain: holds one value, compares it with the
// broadcast value and trades entries with its neighbors.
// ----------------------------------------------------------------------------
module isws_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  isws_pkg::cell_ctrl_t               ctrl,
  input  logic signed [isws_pkg::VALUE_W-1:0] new_value,
  input  logic signed [isws_pkg::VALUE_W-1:0] left_value,
  input  logic                               left_valid,
  input  logic                               left_ge,
  input  logic signed [isws_pkg::VALUE_W-1:0] right_value,
  input  logic                               right_valid,
  output logic signed [isws_pkg::VALUE_W-1:0] value_q,
  output logic                               valid_q,
  output logic                               ge
);
  import isws_pkg::*;

  logic signed [VALUE_W-1:0] value_next;
  logic                      valid_next;

  // An empty cell counts as greater so that the new value lands in the
  // first free cell when nothing stored exceeds it.
  assign ge = !valid_q || (value_q > new_value);

  always_comb begin
    value_next = value_q;
    valid_next = valid_q;
    if (ctrl.shift_down) begin
      value_next = right_value;
      valid_next = right_valid;
    end else if (ctrl.insert) begin
      if (left_ge) begin
        value_next = left_value;
        valid_next = left_valid;
      end else if (ge) begin
        value_next = new_value;
        valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_q <= value_next;
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_next;
    end
  end

endmodule

### sv/isws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isws_checker
// Port-level checks of the insertion sorter's command and result beats.
// ----------------------------------------------------------------------------
`include "insertion_sort_with_step_count_assert.svh"

module isws_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        last,
  input logic                        result_strobe,
  input logic                        last_out,
  input logic [isws_pkg::STEP_W-1:0] step_count,
  input logic                        overflow
);
  import isws_pkg::*;

  `ISWS_ASSERT_NOW(a_strobe_busy, clk, rst, result_strobe, busy)
  `ISWS_ASSERT_NOW(a_last_in_beat, clk, rst, last_out, result_strobe)
  `ISWS_ASSERT_NEXT(a_marked_emits, clk, rst, start && !busy && last, result_strobe)
  `ISWS_ASSERT_NEXT(a_end_frees, clk, rst, last_out, !busy)
  `ISWS_ASSERT_NEXT(a_batch_holds, clk, rst, result_strobe && !last_out,
    result_strobe && $stable(step_count) && $stable(overflow))

endmodule

bind insertion_sort_with_step_count isws_checker u_isws_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last         (last),
  .result_strobe(result_strobe),
  .last_out     (last_out),
  .step_count   (step_count),
  .overflow     (overflow)
);

### tb/tb_insertion_sort_with_step_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_insertion_sort_with_step_count
// Feeds batches of signed values into the insertion sorter and checks every
// streamed result beat against a behavioral sorter that keeps its own store,
// step total and drop flag.
// ----------------------------------------------------------------------------
module tb_insertion_sort_with_step_count;

  localparam int DEPTH      = isws_pkg::MAX_ITEMS_DEFAULT;
  localparam int VW         = isws_pkg::VALUE_W;
  localparam int SW         = isws_pkg::STEP_W;
  localparam int STEP_SAT   = 8191;
  localparam int CYCLE_CAP  = 100000;
  localparam int DRAIN_WAIT = 20;
  localparam int RAND_ITEMS = 105;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_CLUSTER,
    SHAPE_FALLING,
    SHAPE_RISING,
    SHAPE_EDGES
  } batch_shape_t;

  typedef struct {
    logic signed [VW-1:0] value;
    logic                 last;
  } feed_item_t;

  typedef struct {
    logic signed [VW-1:0] value;
    logic                 last_out;
    logic [SW-1:0]        steps;
    logic                 dropped;
  } sorted_row_t;

  logic                 clk   = 1'b0;
  logic                 rst   = 1'b1;
  logic                 start = 1'b0;
  logic signed [VW-1:0] value = '0;
  logic                 last  = 1'b0;
  logic                 busy;
  logic                 result_strobe;
  logic signed [VW-1:0] sorted_value;
  logic                 last_out;
  logic [SW-1:0]        step_count;
  logic                 overflow;

  insertion_sort_with_step_count #(.MAX_ITEMS(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last         (last),
    .result_strobe(result_strobe),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .step_count   (step_count),
    .overflow     (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  feed_item_t  feed_q[$];
  sorted_row_t sorted_due[$];
  feed_item_t  drive_item;

  // Shadow sorter state.
  logic signed [VW-1:0] shadow [DEPTH];
  int   held   = 0;
  int   steps  = 0;
  logic spill  = 1'b0;

  int   errors      = 0;
  int   sent        = 0;
  int   accepted    = 0;
  int   checked     = 0;
  int   batches     = 0;
  int   spill_runs  = 0;
  int   cycles      = 0;
  logic took        = 1'b0;
  logic steady;

  // Items 40 through 79 go out back to back while the sorter is not busy.
  assign steady = (sent >= 40 && sent < 80);

  task automatic take_value(input logic signed [VW-1:0] v, input logic is_last);
    int          slot;
    int          above;
    sorted_row_t row;
    if (held >= DEPTH) begin
      spill = 1'b1;
    end else begin
      slot  = held;
      above = 0;
      while (slot > 0 && shadow[slot-1] > v) begin
        shadow[slot] = shadow[slot-1];
        slot--;
        above++;
      end
      shadow[slot] = v;
      if (held > 0) begin
        steps = steps + 2 + 2 * above;
        if (steps > STEP_SAT) steps = STEP_SAT;
      end
      held++;
    end
    if (is_last) begin
      batches++;
      if (spill) spill_runs++;
      for (int k = 0; k < held; k++) begin
        row.value    = shadow[k];
        row.last_out = (k == held - 1);
        row.steps    = steps[SW-1:0];
        row.dropped  = spill;
        sorted_due.push_back(row);
      end
      held  = 0;
      steps = 0;
      spill = 1'b0;
    end
  endtask

  task automatic push_item(input logic signed [VW-1:0] v, input logic is_last);
    feed_item_t it;
    it.value = v;
    it.last  = is_last;
    feed_q.push_back(it);
  endtask

  task automatic queue_batch(input int len, input batch_shape_t shape);
    int                   gap;
    logic signed [VW-1:0] v;
    gap = $urandom_range(1, 100000);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_RANDOM:  v = $urandom;
        SHAPE_CLUSTER: v = $signed($urandom_range(0, 7)) - 4;
        SHAPE_FALLING: v = 32'sh7FFF_FFFF - i * gap;
        SHAPE_RISING:  v = 32'sh8000_0000 + i * gap;
        default: begin
          case ($urandom_range(0, 4))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7FFF_FFFF;
            2:       v = '0;
            3:       v = -1;
            default: v = $urandom;
          endcase
        end
      endcase
      push_item(v, i == len - 1);
    end
  endtask

  // Driver: a beat stays on the pins until it has been taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (feed_q.size() > 0 && (steady || $urandom_range(0, 99) >= 34)) begin
        drive_item = feed_q.pop_front();
        start <= 1'b1;
        value <= drive_item.value;
        last  <= drive_item.last;
        sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: inputs taken and results streamed are both seen at the rising edge.
  always @(posedge clk) begin
    sorted_row_t row;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
    took <= start && !busy && !rst;
    if (!rst) begin
      if (start && !busy) begin
        accepted++;
        take_value(value, last);
      end
      if (result_strobe) begin
        if (sorted_due.size() == 0) begin
          $error("unexpected result beat: sorted_value %0d", sorted_value);
          errors++;
        end else begin
          row = sorted_due.pop_front();
          checked++;
          if (sorted_value !== row.value) begin
            $error("sorted_value: expected %0d, got %0d", row.value, sorted_value);
            errors++;
          end
          if (last_out !== row.last_out) begin
            $error("last_out: expected %0d, got %0d", row.last_out, last_out);
            errors++;
          end
          if (step_count !== row.steps) begin
            $error("step_count: expected %0d, got %0d", row.steps, step_count);
            errors++;
          end
          if (overflow !== row.dropped) begin
            $error("overflow: expected %0d, got %0d", row.dropped, overflow);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int           fill_goal;
    int           len;
    int           pick;
    batch_shape_t shape;

    // Directed: a lone value, the extremes with duplicates, then a full
    // falling batch that costs the most steps.
    push_item(32'sh7FFF_FFFF, 1'b1);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(-1, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(5, 1'b1);
    queue_batch(DEPTH, SHAPE_FALLING);

    // Random batches; the first one always runs past capacity.
    fill_goal = feed_q.size() + RAND_ITEMS;
    queue_batch(DEPTH + 2, SHAPE_RANDOM);
    while (feed_q.size() < fill_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      len = 1;
      else if (pick < 70) len = $urandom_range(2, DEPTH - 1);
      else if (pick < 85) len = DEPTH;
      else                len = $urandom_range(DEPTH + 1, DEPTH + 6);
      shape = batch_shape_t'($urandom_range(0, 4));
      queue_batch(len, shape);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (feed_q.size() > 0 || start) @(posedge clk);
    while (sorted_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d values in %0d batches, %0d of them past capacity.",
             accepted, batches, spill_runs);
    $display("Checked %0d sorted result beats.", checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
